FILE: sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions for the sorted key table
// Field widths, action and status codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Default sizing of the table.
  localparam int SKT_CAPACITY  = 64;
  localparam int SKT_KEY_WIDTH = 32;

  // Port field widths.
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Actions.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_ALLOW_DUP = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_UP,
    S_INS_WR,
    S_RM_RD,
    S_SHIFT_DN,
    S_DONE
  } state_t;

endpackage

FILE: sv/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic single write port, single read port RAM
// Write at one address and read at another each cycle; read data is registered.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sorted_key_table.sv
// Steps: a find probes the table by binary search; an insert searches, moves the entries
// above the insertion point up one place and writes the key; a remove reads the entry at
// the index and moves the later entries down one place; clear and a bad index go straight
// to the result.
// Throughput: one word at a time; a result still held in the output register stalls the next.
// Reset (synchronous, rst high) empties the table and clears allow_duplicates; RAM is kept.
// ----------------------------------------------------------------------------
// sorted_key_table: ascending table of unsigned keys with search, insert and remove
// A small sequencer drives one RAM and one comparator through a binary search and
// through the entry shifts of insert and remove.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY  = skt_pkg::SKT_CAPACITY,
  parameter int KEY_WIDTH = skt_pkg::SKT_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input words.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [skt_pkg::ACTION_W-1:0]  action,
  input  logic [skt_pkg::KEY_W-1:0]     key,
  input  logic [skt_pkg::INDEX_W-1:0]   index,
  // Result words.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skt_pkg::STATUS_W-1:0]  status,
  output logic [skt_pkg::POS_W-1:0]     position,
  output logic [skt_pkg::KEY_W-1:0]     key_out,
  output logic [skt_pkg::COUNT_W-1:0]   entry_count,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skt_pkg::PADDR_W-1:0]   paddr,
  input  logic [skt_pkg::PDATA_W-1:0]   pwdata,
  output logic [skt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import skt_pkg::*;

  // CW holds a count up to CAPACITY, AW addresses the RAM.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  state_t state, state_next;

  // Configuration register.
  logic allow_dup;

  // Table occupancy.
  logic [CW-1:0] count;

  // Working registers of the current word.
  logic [ACTION_W-1:0]  act_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi_excl;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        ptr;
  logic                 pend;
  logic                 first;
  logic [STATUS_W-1:0]  res_status;
  logic [POS_W-1:0]     res_pos;
  logic [KEY_WIDTH-1:0] res_key;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] rd_data;

  // Combinational helpers.
  logic                 in_take;
  logic                 out_load;
  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_W-1:0]     key_wide;
  logic [CW-1:0]        mid_c;
  logic                 srch_end;
  logic                 end_hit;
  logic [CW-1:0]        end_pos;
  logic                 ins_reject;
  logic                 bad_index;
  logic                 up_more;
  logic                 dn_more;

  skt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // The key port is masked down to the stored key width.
  always_comb begin
    key_in = '0;
    for (int b = 0; b < KEY_WIDTH && b < KEY_W; b++) begin
      key_in[b] = key[b];
    end
  end

  always_comb begin
    key_wide = '0;
    for (int b = 0; b < KEY_WIDTH && b < KEY_W; b++) begin
      key_wide[b] = res_key[b];
    end
  end

  assign in_take = in_valid && in_ready;

  // A finished result moves into the output register only once it is free.
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Remove is rejected when the given index is not below the count.
  assign bad_index = IW'(index) >= IW'(count);

  // Midpoint of the inclusive range [lo, hi_excl-1].
  assign mid_c = CW'(({1'b0, lo} + {1'b0, hi_excl} - 1'b1) >> 1);

  // The search ends either on an empty range (a miss at lo) or on an equal probe.
  always_comb begin
    srch_end = 1'b0;
    end_hit  = 1'b0;
    end_pos  = lo;
    if (state == S_SRCH_RD) begin
      srch_end = lo >= hi_excl;
    end else if (state == S_SRCH_CMP) begin
      srch_end = key_r == rd_data;
      end_hit  = 1'b1;
      end_pos  = mid;
    end
  end

  // An insert is dropped on a duplicate first, then on a full table.
  assign ins_reject = (end_hit && !allow_dup) || (count >= CW'(CAPACITY));

  // Shifting up stops once the pointer has reached the insertion point;
  // shifting down stops at the last valid entry.
  assign up_more = ptr > pos;
  assign dn_more = ({1'b0, ptr} + 1'b1) < {1'b0, count};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (action == ACT_CLEAR) begin
            state_next = S_DONE;
          end else if (action == ACT_REMOVE) begin
            state_next = bad_index ? S_DONE : S_RM_RD;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD, S_SRCH_CMP: begin
        if (srch_end) begin
          if (act_r == ACT_INSERT && !ins_reject) begin
            state_next = S_SHIFT_UP;
          end else begin
            state_next = S_DONE;
          end
        end else if (state == S_SRCH_RD) begin
          state_next = S_SRCH_CMP;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SHIFT_UP: state_next = up_more ? S_SHIFT_UP : S_INS_WR;
      S_INS_WR:   state_next = S_DONE;
      S_RM_RD:    state_next = S_SHIFT_DN;
      S_SHIFT_DN: state_next = dn_more ? S_SHIFT_DN : S_DONE;
      S_DONE:     state_next = out_load ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM control.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rd_data;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_SRCH_RD: ram_raddr = AW'(mid_c);
      S_SHIFT_UP: begin
        // The entry read last cycle lands one place above the current pointer.
        ram_we    = pend;
        ram_waddr = AW'(ptr + 1'b1);
        if (up_more) begin
          ram_raddr = AW'(ptr - 1'b1);
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos);
        ram_wdata = key_r;
      end
      S_RM_RD: ram_raddr = AW'(ptr);
      S_SHIFT_DN: begin
        // The first read returns the removed key; later reads move down by one.
        ram_we    = !first;
        ram_waddr = AW'(ptr - 1'b1);
        if (dn_more) begin
          ram_raddr = AW'(ptr + 1'b1);
        end
      end
      S_SRCH_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;

      if (in_take) begin
        act_r      <= action;
        key_r      <= key_in;
        lo         <= '0;
        hi_excl    <= count;
        ptr        <= CW'(index);
        res_key    <= '0;
        first      <= 1'b1;
        if (action == ACT_CLEAR) begin
          count <= '0;
        end
        if (action == ACT_REMOVE) begin
          res_pos    <= POS_W'(index);
          res_status <= bad_index ? ST_BAD_INDEX : ST_OK;
        end else begin
          res_pos    <= '0;
          res_status <= ST_OK;
        end
      end

      if (state == S_SRCH_RD && !srch_end) begin
        mid <= mid_c;
      end

      if (state == S_SRCH_CMP && !srch_end) begin
        if (key_r < rd_data) begin
          hi_excl <= mid;
        end else begin
          lo <= mid + 1'b1;
        end
      end

      if (srch_end) begin
        pos     <= end_pos;
        res_pos <= POS_W'(end_pos);
        if (act_r == ACT_FIND) begin
          res_status <= end_hit ? ST_OK : ST_NOT_FOUND;
        end else if (end_hit && !allow_dup) begin
          res_status <= ST_DUPLICATE;
        end else if (count >= CW'(CAPACITY)) begin
          res_status <= ST_FULL;
        end else begin
          ptr  <= count;
          pend <= 1'b0;
        end
      end

      if (state == S_SHIFT_UP) begin
        if (up_more) begin
          ptr  <= ptr - 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end

      if (state == S_INS_WR) begin
        count <= count + 1'b1;
      end

      if (state == S_SHIFT_DN) begin
        first <= 1'b0;
        if (first) begin
          res_key <= rd_data;
        end
        if (dn_more) begin
          ptr <= ptr + 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      position    <= res_pos;
      key_out     <= key_wide;
      entry_count <= COUNT_W'(count);
    end
  end

  // Configuration register: written on the access cycle of an APB write.
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_dup <= 1'b0;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_ALLOW_DUP) begin
      allow_dup <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_ALLOW_DUP) begin
      prdata[0] = allow_dup;
    end
  end

  assign pready = 1'b1;

`ifndef NO_ASSERTIONS
  // The entry count never goes beyond the table's capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Every RAM write lands at or below the current count.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, ram_waddr} <= (AW + 1)'(count)))
    else $error("RAM write beyond the occupied range");

  // A new result appears only after the sequencer finished a word.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised without a finished word");

  // An accepted word keeps the block busy in the cycle after it is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("input accepted again in the cycle after a take");
`endif

endmodule

FILE: sim/tb_sorted_key_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table: self-checking testbench for the sorted key table
// Drives insert, find, remove and clear words under several handshake idle
// patterns and both duplicate settings. Every result word is compared with a
// local prediction of the table.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  // Random words per phase.
  localparam int RANDOM_PER_PHASE = 170;
  // Cycles without any word accepted or result taken before the run is declared hung.
  localparam int WATCHDOG_LIMIT   = 2000;
  // Idle cycles after the last result before a register write or the end.
  localparam int SETTLE_CYCLES    = 8;
  localparam int END_CYCLES       = 100;
  // Mismatch lines printed before further ones are only counted.
  localparam int MAX_PRINTED      = 100;

  // One input word and one result word, at the widths of the ports.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [INDEX_W-1:0]  index;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  entries;
  } table_result_t;

  // Every input of the block starts at a known value.
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] action = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [INDEX_W-1:0]  index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [KEY_W-1:0]    key_out;
  logic [COUNT_W-1:0]  entry_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sorted_key_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .key         (key),
    .index       (index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .key_out     (key_out),
    .entry_count (entry_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. It is updated when a word is accepted, so it
  // always reflects every word the block has taken so far.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] tbl_keys [SKT_CAPACITY];
  int               tbl_count = 0;
  bit               dup_allowed = 1'b0;

  table_op_t        queued_ops[$];          // words waiting for the driver
  table_result_t    predicted_outcomes[$];  // results owed by the block
  table_op_t        cur_op;                 // word currently on the input port
  int               src_idle_pct = 0;       // chance per cycle of holding back a word
  int               sink_stall_pct = 0;     // chance per cycle of refusing a result
  int               errors = 0;

  // Binary search with inclusive bounds and midpoint (lo+hi)>>1. It stops at the
  // first equal key it probes; otherwise it returns the insertion point.
  function automatic int locate_key(input logic [KEY_W-1:0] k, output bit hit);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_count - 1;
    hit = 1'b0;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (k == tbl_keys[mid]) begin
        hit = 1'b1;
        return mid;
      end
      if (k < tbl_keys[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // Applies one word to the shadow table and returns the result the block owes.
  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t r;
    int            pos;
    int            i;
    bit            hit;
    r = '0;
    r.status = ST_OK;
    case (op.action)
      ACT_INSERT: begin
        pos = locate_key(op.key, hit);
        r.position = POS_W'(pos);
        // The duplicate check wins over the full check.
        if (hit && !dup_allowed) begin
          r.status = ST_DUPLICATE;
        end else if (tbl_count >= SKT_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = tbl_count; i > pos; i--) tbl_keys[i] = tbl_keys[i-1];
          tbl_keys[pos] = op.key;
          tbl_count++;
        end
      end
      ACT_FIND: begin
        pos = locate_key(op.key, hit);
        r.position = POS_W'(pos);
        r.status = hit ? ST_OK : ST_NOT_FOUND;
      end
      ACT_REMOVE: begin
        r.position = POS_W'(op.index);
        if (int'(op.index) >= tbl_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.key_out = tbl_keys[op.index];
          for (i = op.index; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
          tbl_count--;
        end
      end
      default: begin
        tbl_count = 0;
      end
    endcase
    r.entries = COUNT_W'(tbl_count);
    return r;
  endfunction

  // Key source: mostly fresh keys for inserts, mostly held keys (or their
  // neighbors) for finds, so that hits, misses and duplicates all occur.
  function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
    logic [KEY_W-1:0] held;
    if (tbl_count != 0 && $urandom_range(0, 99) >= fresh_pct) begin
      held = tbl_keys[$urandom_range(0, tbl_count - 1)];
      case ($urandom_range(0, 3))
        0: return held - 1'b1;
        1: return held + 1'b1;
        default: return held;
      endcase
    end
    case ($urandom_range(0, 7))
      0: return KEY_W'($urandom_range(0, 15));
      1: return '1 - KEY_W'($urandom_range(0, 15));
      2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return KEY_W'($urandom());
    endcase
  endfunction

  // Inserts outweigh removes so the table keeps filling up to capacity; once
  // full it is cleared now and then so the cycle repeats.
  function automatic table_op_t random_table_op();
    table_op_t op;
    int        roll;
    roll = $urandom_range(0, 199);
    op.key = KEY_W'($urandom());
    op.index = INDEX_W'($urandom());
    if (roll == 0 || (tbl_count == SKT_CAPACITY && $urandom_range(0, 9) == 0)) begin
      op.action = ACT_CLEAR;
    end else if (roll < 130) begin
      op.action = ACT_INSERT;
      op.key = pick_key(85);
    end else if (roll < 166) begin
      op.action = ACT_FIND;
      op.key = pick_key(40);
    end else begin
      op.action = ACT_REMOVE;
      if (tbl_count != 0 && $urandom_range(0, 99) < 85)
        op.index = INDEX_W'($urandom_range(0, tbl_count - 1));
    end
    return op;
  endfunction

  task automatic push_op(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k,
                         input logic [INDEX_W-1:0] idx);
    table_op_t op;
    op.action = act;
    op.key = k;
    op.index = idx;
    queued_ops.push_back(op);
  endtask

  // Every mismatch goes through here: one line for each of the first MAX_PRINTED, and the count that decides the end.
  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued words. A word stays on the port unchanged until it
  // is taken; the prediction is made at the edge where it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_outcomes.push_back(apply_table_op(cur_op));
      if (!in_valid || in_ready) begin
        if (queued_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_op = queued_ops.pop_front();
          action <= cur_op.action;
          key <= cur_op.key;
          index <= cur_op.index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words with random back-pressure and checks each one
  // field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outcomes.size() == 0) begin
          flag_error($sformatf("result word with none expected (status %0d position %0d)",
                               status, position));
        end else begin
          want = predicted_outcomes.pop_front();
          if (status !== want.status)
            flag_error($sformatf("status %0d, expected %0d", status, want.status));
          if (position !== want.position)
            flag_error($sformatf("position %0d, expected %0d", position, want.position));
          if (key_out !== want.key_out)
            flag_error($sformatf("key_out %h, expected %h", key_out, want.key_out));
          if (entry_count !== want.entries)
            flag_error($sformatf("entry_count %0d, expected %0d", entry_count, want.entries));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog: ends the run when neither side has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Waits until every queued word has been taken and every result has come
  // back, then idles for the settle period so the sequencer is surely back in idle.
  // Sampling at the falling edge keeps this clear of the clocked processes.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_ops.size() != 0 || in_valid || predicted_outcomes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic write_allow_dup(input bit value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_ALLOW_DUP) << 2;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dup_allowed = value;
  endtask

  // Feeds random words a couple at a time, so that the generator sees a table
  // that is close to the one the block holds.
  task automatic feed_random(input int n_ops);
    repeat (n_ops) begin
      while (queued_ops.size() >= 2) @(negedge clk);
      queued_ops.push_back(random_table_op());
    end
  endtask

  task automatic run_phase(input int idle_in, input int stall_out, input bit dup);
    wait_drained();
    write_allow_dup(dup);
    @(negedge clk);
    src_idle_pct = idle_in;
    sink_stall_pct = stall_out;
    feed_random(RANDOM_PER_PHASE);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_allow_dup(1'b0);

    // Directed words: empty table, extreme keys, a duplicate, hits at both
    // ends and misses, removes of the first and last entry and past the
    // end, and clears.
    push_op(ACT_FIND,   32'h0000_0000, 6'd0);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd0);
    push_op(ACT_INSERT, 32'h8000_0000, 6'd0);
    push_op(ACT_INSERT, 32'h0000_0000, 6'd0);
    push_op(ACT_INSERT, 32'hFFFF_FFFF, 6'd0);
    push_op(ACT_INSERT, 32'h8000_0000, 6'd0);
    push_op(ACT_INSERT, 32'h7FFF_FFFF, 6'd0);
    push_op(ACT_INSERT, 32'h8000_0001, 6'd0);
    push_op(ACT_FIND,   32'hFFFF_FFFF, 6'd0);
    push_op(ACT_FIND,   32'h0000_0000, 6'd0);
    push_op(ACT_FIND,   32'h1234_5678, 6'd0);
    push_op(ACT_FIND,   32'hFFFF_FFFE, 6'd0);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd63);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd5);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd4);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd0);
    push_op(ACT_CLEAR,  32'hFFFF_FFFF, 6'd63);
    push_op(ACT_FIND,   32'h8000_0000, 6'd0);
    push_op(ACT_INSERT, 32'h5555_5555, 6'd0);
    push_op(ACT_INSERT, 32'hAAAA_AAAA, 6'd0);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'h2A);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'h15);
    push_op(ACT_REMOVE, 32'h0000_0000, 6'd1);
    push_op(ACT_CLEAR,  32'h0000_0000, 6'd0);
    feed_random(RANDOM_PER_PHASE);

    // The table carries over from phase to phase; only the duplicate setting
    // and the idle pattern change.
    run_phase(54, 0, 1'b1);
    run_phase(0, 54, 1'b0);
    run_phase(18, 18, 1'b1);
    run_phase(0, 0, 1'b0);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (predicted_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", predicted_outcomes.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
